// ----- hdl/wmf_pkg.sv -----
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared constants for the window median filter: default geometry limits,
// register reset values and register indexes.
// ----------------------------------------------------------------------------
package wmf_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_RADIUS_DEFAULT = 4;
   localparam int HEIGHT_LIMIT       = 1024;

   localparam int GEOM_W   = 11;
   localparam int RADIUS_W = 3;
   localparam int PIXEL_W  = 8;

   localparam logic [GEOM_W-1:0]   WIDTH_RESET  = 11'd512;
   localparam logic [GEOM_W-1:0]   HEIGHT_RESET = 11'd512;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 3'd2;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH   = 2'd0,
      REG_FRAME_HEIGHT  = 2'd1,
      REG_WINDOW_RADIUS = 2'd2,
      REG_UNUSED        = 2'd3
   } reg_index_type;

endpackage

// ----- hdl/window_median_filter_core.sv -----
// ----------------------------------------------------------------------------
// window_median_filter_core
// Square-window median filter over an 8-bit raster frame, with a ring of
// row storage in one synchronous memory and a radix selection median.
// ----------------------------------------------------------------------------
// Timing: a transaction that makes no result goes through the check state
// and back to idle; one that makes a result runs setup, then eight radix
// passes over the in-frame window pixels (1..81 at radius 4), each reading
// them through the single memory read port, and the result then sits in the
// output register. A new transaction is taken only once the last is done.
// Reset (synchronous, active high) clears counters, pointers and the control
// state and restores the registers to 512 x 512 with radius 2; the pixel
// memory is not cleared.
module window_median_filter_core
   import wmf_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_RADIUS = MAX_RADIUS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [PIXEL_W-1:0] req_pixel_value,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [PIXEL_W-1:0] rsp_filtered_pixel,
   output logic               rsp_last_of_frame,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // The ring holds 2*MAX_RADIUS+1 rows of the widest frame.
   localparam int SIDE  = 2 * MAX_RADIUS + 1;
   localparam int DEPTH = SIDE * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int NS    = $clog2(SIDE + 1);
   localparam int NW    = $clog2(SIDE * SIDE + 1);
   localparam int CW    = 2 * GEOM_W;
   localparam logic [AW:0] DEPTH_C = (AW + 1)'(DEPTH);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CHECK  = 7'b0000010,
      ST_SETUP  = 7'b0000100,
      ST_SCAN   = 7'b0001000,
      ST_DRAIN  = 7'b0010000,
      ST_DECIDE = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [GEOM_W-1:0]   cfg_w_ff, cfg_h_ff;
   logic [RADIUS_W-1:0] cfg_r_ff;
   logic [GEOM_W-1:0]   w_eff, h_eff;
   logic [RADIUS_W-1:0] r_eff;
   logic [CW-1:0]       total;

   logic [CW-1:0]       prx_ff, prx_in;       // pixels received
   logic [CW-1:0]       res_ff, res_in;       // results sent
   logic [AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]       res_ptr_ff, res_ptr_in;
   logic [GEOM_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic [GEOM_W-1:0]   ny_ff, ny_in, nx_ff, nx_in;

   logic [NS-1:0]       rows_ff, rows_in, cols_ff, cols_in;
   logic [NS-1:0]       row_idx_ff, row_idx_in, col_idx_ff, col_idx_in;
   logic [AW-1:0]       tl_ff, tl_in;         // top left of the window
   logic [AW-1:0]       row_base_ff, row_base_in;
   logic [AW-1:0]       cur_ff, cur_in;
   logic [NW-1:0]       n_ff, n_in, k_ff, k_in, cnt_ff, cnt_in;
   logic [2:0]          bit_ff, bit_in;
   logic [PIXEL_W-1:0]  prefix_ff, prefix_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [PIXEL_W-1:0]  rd_data_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]  rsp_pix_ff, rsp_pix_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                mem_we;
   logic [PIXEL_W-1:0]  mem [DEPTH];

   logic                cfg_we, req_fire;
   logic [GEOM_W:0]     y_plus_r, x_plus_r;
   logic [CW:0]         need;
   logic [GEOM_W-1:0]   yl, xl;
   logic [RADIUS_W-1:0] dy_up, dx_left;
   logic [AW:0]         offset, next_base, next_cur;
   logic [PIXEL_W-1:0]  hi_mask;
   logic                last_row, last_col;

   // ---------------------------------------------------------------------
   // Configuration registers. A write restarts the frame.
   // ---------------------------------------------------------------------
   assign pready = 1'b1;
   assign cfg_we = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= WIDTH_RESET;
         cfg_h_ff <= HEIGHT_RESET;
         cfg_r_ff <= RADIUS_RESET;
      end else if (cfg_we) begin
         case (reg_index_type'(paddr[3:2]))
            REG_FRAME_WIDTH:   cfg_w_ff <= pwdata[GEOM_W-1:0];
            REG_FRAME_HEIGHT:  cfg_h_ff <= pwdata[GEOM_W-1:0];
            REG_WINDOW_RADIUS: cfg_r_ff <= pwdata[RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(paddr[3:2]))
         REG_FRAME_WIDTH:   prdata = {21'd0, cfg_w_ff};
         REG_FRAME_HEIGHT:  prdata = {21'd0, cfg_h_ff};
         REG_WINDOW_RADIUS: prdata = {29'd0, cfg_r_ff};
         default:           prdata = 32'd0;
      endcase
   end

   // Out-of-range geometry saturates into the supported range.
   always_comb begin
      if (cfg_w_ff == '0)                      w_eff = GEOM_W'(1);
      else if (32'(cfg_w_ff) > MAX_WIDTH)      w_eff = GEOM_W'(MAX_WIDTH);
      else                                     w_eff = cfg_w_ff;
      if (cfg_h_ff == '0)                      h_eff = GEOM_W'(1);
      else if (32'(cfg_h_ff) > HEIGHT_LIMIT)   h_eff = GEOM_W'(HEIGHT_LIMIT);
      else                                     h_eff = cfg_h_ff;
      if (32'(cfg_r_ff) > MAX_RADIUS)          r_eff = RADIUS_W'(MAX_RADIUS);
      else                                     r_eff = cfg_r_ff;
   end

   assign total = CW'(w_eff) * CW'(h_eff);

   // ---------------------------------------------------------------------
   // Window geometry. The window of the next result reaches down to row
   // min(y+r,H-1) and right to column min(x+r,W-1); the result is ready once
   // that pixel has arrived.
   // ---------------------------------------------------------------------
   assign y_plus_r = {1'b0, y_ff} + (GEOM_W + 1)'(r_eff);
   assign x_plus_r = {1'b0, x_ff} + (GEOM_W + 1)'(r_eff);
   assign ny_in = (y_plus_r > {1'b0, h_eff - 1'b1}) ? h_eff - 1'b1 : y_plus_r[GEOM_W-1:0];
   assign nx_in = (x_plus_r > {1'b0, w_eff - 1'b1}) ? w_eff - 1'b1 : x_plus_r[GEOM_W-1:0];
   assign need  = (CW + 1)'(ny_ff) * (CW + 1)'(w_eff) + (CW + 1)'(nx_ff);

   assign yl      = (y_ff >= GEOM_W'(r_eff)) ? y_ff - GEOM_W'(r_eff) : '0;
   assign xl      = (x_ff >= GEOM_W'(r_eff)) ? x_ff - GEOM_W'(r_eff) : '0;
   assign dy_up   = RADIUS_W'(y_ff - yl);
   assign dx_left = RADIUS_W'(x_ff - xl);
   // Rows above the result row span less than one ring, so a single wrap
   // brings the window's top left corner back into the ring.
   assign offset  = (AW + 1)'(dy_up) * (AW + 1)'(w_eff) + (AW + 1)'(dx_left);

   // Ring address stepping inside the window scan.
   assign next_base = ((AW + 1)'(row_base_ff) + (AW + 1)'(w_eff) >= DEPTH_C)
                    ? (AW + 1)'(row_base_ff) + (AW + 1)'(w_eff) - DEPTH_C
                    : (AW + 1)'(row_base_ff) + (AW + 1)'(w_eff);
   assign next_cur  = ((AW + 1)'(cur_ff) + 1'b1 >= DEPTH_C)
                    ? '0 : (AW + 1)'(cur_ff) + 1'b1;
   assign last_col  = (col_idx_ff == cols_ff - 1'b1);
   assign last_row  = (row_idx_ff == rows_ff - 1'b1);

   // Bits above the one being decided must match the prefix found so far.
   assign hi_mask = ~(8'hFF >> (3'd7 - bit_ff));

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign mem_we    = req_fire & ~req_kind & (prx_ff < total);

   // ---------------------------------------------------------------------
   // Control. Each pixel transaction stores its pixel unless the frame is
   // full, then every transaction checks readiness; a ready result runs eight
   // radix passes over the window held in the ring, one memory read per cycle
   // while scanning, picking element n/2 of the values in descending order.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      prx_in       = prx_ff;
      res_in       = res_ff;
      wr_ptr_in    = wr_ptr_ff;
      res_ptr_in   = res_ptr_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      row_idx_in   = row_idx_ff;
      col_idx_in   = col_idx_ff;
      tl_in        = tl_ff;
      row_base_in  = row_base_ff;
      cur_in       = cur_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      bit_in       = bit_ff;
      prefix_in    = prefix_ff;
      rd_vld_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_pix_in   = rsp_pix_ff;
      rsp_last_in  = rsp_last_ff;

      if (rd_vld_ff && ((rd_data_ff ^ prefix_ff) & hi_mask) == '0 && rd_data_ff[bit_ff]) begin
         cnt_in = cnt_ff + 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (mem_we) begin
                  prx_in    = prx_ff + 1'b1;
                  wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (res_ff < total && (CW + 1)'(prx_ff) > need) begin
               state_in = ST_SETUP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SETUP: begin
            rows_in     = NS'(ny_ff - yl + 1'b1);
            cols_in     = NS'(nx_ff - xl + 1'b1);
            n_in        = NW'(rows_in) * NW'(cols_in);
            k_in        = n_in >> 1;
            tl_in       = (offset > (AW + 1)'(res_ptr_ff))
                        ? AW'((AW + 1)'(res_ptr_ff) + DEPTH_C - offset)
                        : AW'((AW + 1)'(res_ptr_ff) - offset);
            row_base_in = tl_in;
            cur_in      = tl_in;
            row_idx_in  = '0;
            col_idx_in  = '0;
            cnt_in      = '0;
            bit_in      = 3'd7;
            prefix_in   = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            rd_vld_in = 1'b1;
            if (!last_col) begin
               col_idx_in = col_idx_ff + 1'b1;
               cur_in     = AW'(next_cur);
            end else begin
               col_idx_in  = '0;
               row_idx_in  = row_idx_ff + 1'b1;
               row_base_in = AW'(next_base);
               cur_in      = AW'(next_base);
               if (last_row) state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (k_ff < cnt_ff) prefix_in[bit_ff] = 1'b1;
            else               k_in = k_ff - cnt_ff;
            if (bit_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               bit_in      = bit_ff - 1'b1;
               cnt_in      = '0;
               row_idx_in  = '0;
               col_idx_in  = '0;
               row_base_in = tl_ff;
               cur_in      = tl_ff;
               state_in    = ST_SCAN;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = prefix_ff;
               rsp_last_in  = (res_ff + 1'b1 == total);
               state_in     = ST_IDLE;
               if (res_ff + 1'b1 == total) begin
                  // Frame complete: the next pixel starts a new frame.
                  prx_in     = '0;
                  res_in     = '0;
                  wr_ptr_in  = '0;
                  res_ptr_in = '0;
                  x_in       = '0;
                  y_in       = '0;
               end else begin
                  res_in     = res_ff + 1'b1;
                  res_ptr_in = (32'(res_ptr_ff) == DEPTH - 1) ? '0 : res_ptr_ff + 1'b1;
                  if (x_ff == w_eff - 1'b1) begin
                     x_in = '0;
                     y_in = y_ff + 1'b1;
                  end else begin
                     x_in = x_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cfg_we) begin
         prx_in     = '0;
         res_in     = '0;
         wr_ptr_in  = '0;
         res_ptr_in = '0;
         x_in       = '0;
         y_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prx_ff       <= '0;
         res_ff       <= '0;
         wr_ptr_ff    <= '0;
         res_ptr_ff   <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prx_ff       <= prx_in;
         res_ff       <= res_in;
         wr_ptr_ff    <= wr_ptr_in;
         res_ptr_ff   <= res_ptr_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ny_ff       <= ny_in;
      nx_ff       <= nx_in;
      rows_ff     <= rows_in;
      cols_ff     <= cols_in;
      row_idx_ff  <= row_idx_in;
      col_idx_ff  <= col_idx_in;
      tl_ff       <= tl_in;
      row_base_ff <= row_base_in;
      cur_ff      <= cur_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      cnt_ff      <= cnt_in;
      bit_ff      <= bit_in;
      prefix_ff   <= prefix_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Pixel ring: one write port for arriving pixels, one registered read
   // port for the window scan.
   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_ptr_ff] <= req_pixel_value;
      rd_data_ff <= mem[cur_ff];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_pixel = rsp_pix_ff;
   assign rsp_last_of_frame  = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_results_trail_pixels: assert property (@(posedge clock) disable iff (reset)
      res_ff <= prx_ff) else $error("more results than pixels in frame");

   a_scan_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> (row_idx_ff < rows_ff && col_idx_ff < cols_ff))
      else $error("window scan out of bounds");

   a_rank_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DECIDE) |-> k_ff < n_ff)
      else $error("median rank beyond window count");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=> state_ff == ST_DONE)
      else $error("pending result overwritten");

endmodule

// ----- tb/window_median_filter_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window_median_filter_core_test
// Self-checking testbench for the window median filter. A predictor in the
// testbench keeps its own pixel ring and frame counters and works out the
// expected median for every accepted transaction. A checker process compares
// each result transaction against the oldest expectation. Directed geometry,
// pixel extremes and a long result stall come first, then random frames with
// random idling on both channels.
// ----------------------------------------------------------------------------
module window_median_filter_core_test;
   import wmf_pkg::*;

   localparam bit KIND_PIXEL = 1'b0;
   localparam bit KIND_FLUSH = 1'b1;
   localparam int RING_DEPTH = (2 * MAX_RADIUS_DEFAULT + 1) * MAX_WIDTH_DEFAULT;
   // Settling time that covers the longest transaction, a full 81-pixel window at radius 4.
   localparam int SETTLE_CYCLES = 700;

   typedef struct {
      logic [PIXEL_W-1:0] filtered;
      logic               last;
   } median_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_kind = KIND_PIXEL;
   logic [PIXEL_W-1:0] req_pixel_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [PIXEL_W-1:0] rsp_filtered_pixel;
   logic               rsp_last_of_frame;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   window_median_filter_core DUT (.*);

   // Predictor state: its own copy of the pixel ring, counters and geometry.
   logic [PIXEL_W-1:0] pixel_ring [RING_DEPTH];
   int unsigned pixels_in;
   int unsigned medians_out;
   int unsigned eff_width = 512;
   int unsigned eff_height = 512;
   int unsigned eff_radius = 2;
   median_result_type expected_medians [$];

   int  mismatch_count = 0;
   int  item_count = 0;
   int  median_count = 0;
   int  frame_count = 0;
   int  setting_count = 0;
   bit  no_idle = 1'b0;
   int  rsp_hold = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Median of the in-frame window around raster position (xk, yk), taken
   // at index count/2 of the values sorted from largest to smallest.
   function automatic logic [PIXEL_W-1:0] window_median(int xk, int yk);
      int vals [$];
      int yy;
      int xx;
      for (int dy = -int'(eff_radius); dy <= int'(eff_radius); dy++) begin
         yy = yk + dy;
         if (yy < 0 || yy >= int'(eff_height)) continue;
         for (int dx = -int'(eff_radius); dx <= int'(eff_radius); dx++) begin
            xx = xk + dx;
            if (xx < 0 || xx >= int'(eff_width)) continue;
            vals.push_back(pixel_ring[(yy * eff_width + xx) % RING_DEPTH]);
         end
      end
      vals.rsort();
      return PIXEL_W'(vals[vals.size() / 2]);
   endfunction

   // Works out what one accepted input transaction produces.
   function automatic void predict_median(logic kind, logic [PIXEL_W-1:0] value);
      int unsigned total;
      int unsigned xk;
      int unsigned yk;
      int unsigned ny;
      int unsigned nx;
      median_result_type res;
      total = eff_width * eff_height;
      // Pixels past the end of the frame are dropped.
      if (kind == KIND_PIXEL && pixels_in < total) begin
         pixel_ring[pixels_in % RING_DEPTH] = value;
         pixels_in++;
      end
      if (medians_out >= total) return;
      xk = medians_out % eff_width;
      yk = medians_out / eff_width;
      ny = (yk + eff_radius > eff_height - 1) ? eff_height - 1 : yk + eff_radius;
      nx = (xk + eff_radius > eff_width - 1) ? eff_width - 1 : xk + eff_radius;
      // The window's bottom-right in-frame pixel must have arrived.
      if (pixels_in <= ny * eff_width + nx) return;
      res.filtered = window_median(xk, yk);
      medians_out++;
      res.last = (medians_out == total);
      expected_medians.push_back(res);
      if (res.last) begin
         pixels_in = 0;
         medians_out = 0;
         frame_count++;
      end
   endfunction

   // Sends one input transaction after a random gap and predicts its effect.
   task automatic send_item(logic kind, logic [PIXEL_W-1:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_pixel_value <= value;
      do @(posedge clock); while (!req_ready);
      predict_median(kind, value);
      item_count++;
   endtask

   // Waits until the block is idle: every expected result out, plus the
   // settling time of the longest transaction.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_medians.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB write: setup phase, then access phase. Any write starts a frame.
   task automatic write_register(reg_index_type idx, int unsigned value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 4'(idx) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_FRAME_WIDTH: begin
            eff_width = 32'(value[GEOM_W-1:0]);
            if (eff_width < 1) eff_width = 1;
            if (eff_width > MAX_WIDTH_DEFAULT) eff_width = MAX_WIDTH_DEFAULT;
         end
         REG_FRAME_HEIGHT: begin
            eff_height = 32'(value[GEOM_W-1:0]);
            if (eff_height < 1) eff_height = 1;
            if (eff_height > HEIGHT_LIMIT) eff_height = HEIGHT_LIMIT;
         end
         REG_WINDOW_RADIUS: begin
            eff_radius = 32'(value[RADIUS_W-1:0]);
            if (eff_radius > MAX_RADIUS_DEFAULT) eff_radius = MAX_RADIUS_DEFAULT;
         end
         default: ;
      endcase
      pixels_in = 0;
      medians_out = 0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(int unsigned w, int unsigned h, int unsigned r);
      wait_idle();
      write_register(REG_FRAME_WIDTH, w);
      write_register(REG_FRAME_HEIGHT, h);
      write_register(REG_WINDOW_RADIUS, r);
      setting_count++;
   endtask

   // A complete frame with random content. Flush transactions are sprinkled
   // in, and once all pixels are in, flushes and dropped pixels drain it.
   task automatic send_frame();
      int done_before;
      done_before = frame_count;
      while (frame_count == done_before) begin
         if (pixels_in == eff_width * eff_height)
            send_item(($urandom_range(0, 9) < 3) ? KIND_PIXEL : KIND_FLUSH, 8'($urandom));
         else
            send_item(($urandom_range(0, 9) == 0) ? KIND_FLUSH : KIND_PIXEL, 8'($urandom));
      end
   endtask

   // Checker: compares every result transaction with the oldest expectation.
   initial begin
      median_result_type exp_res;
      int gap;
      @(negedge reset);
      @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         median_count++;
         if (expected_medians.size() == 0) begin
            $error("unexpected result transaction: filtered_pixel %0d", rsp_filtered_pixel);
            mismatch_count++;
         end else begin
            exp_res = expected_medians.pop_front();
            if (rsp_filtered_pixel !== exp_res.filtered) begin
               $error("filtered_pixel expected %0d actual %0d",
                      exp_res.filtered, rsp_filtered_pixel);
               mismatch_count++;
            end
            if (rsp_last_of_frame !== exp_res.last) begin
               $error("last_of_frame expected %0d actual %0d",
                      exp_res.last, rsp_last_of_frame);
               mismatch_count++;
            end
         end
         // A pending long hold takes priority over the usual random stall.
         if (rsp_hold > 0) begin
            gap = rsp_hold;
            rsp_hold = 0;
         end else begin
            gap = no_idle ? 0 : $urandom_range(0, 18);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // The reset geometry is 512 x 512 with radius 2: a few pixels go in but
   // no result can be ready yet.
   task automatic test_reset_geometry();
      for (int i = 0; i < 4; i++) send_item(KIND_PIXEL, 8'(i * 85));
   endtask

   // Tiny 3 x 2 frame, radius 1: extreme pixel values, a flush with nothing
   // ready, and pixels past the frame end that must be dropped.
   task automatic test_small_frame();
      set_geometry(3, 2, 1);
      send_item(KIND_FLUSH, 8'hFF);
      send_item(KIND_PIXEL, 8'h00);
      send_item(KIND_PIXEL, 8'hFF);
      send_item(KIND_PIXEL, 8'h80);
      send_item(KIND_PIXEL, 8'h7F);
      send_item(KIND_PIXEL, 8'h01);
      send_item(KIND_PIXEL, 8'hFE);
      send_item(KIND_PIXEL, 8'h55);
      send_item(KIND_PIXEL, 8'hAA);
      while (pixels_in != 0) send_item(KIND_FLUSH, 8'h00);
   endtask

   // Out-of-range register values saturate: width and height of zero become
   // one, radius above the maximum is clamped, oversized width and height
   // clamp to the limits.
   task automatic test_saturation();
      set_geometry(0, 0, 7);
      send_item(KIND_PIXEL, 8'hFF);
      send_item(KIND_PIXEL, 8'h00);
      send_item(KIND_FLUSH, 8'h3C);
      set_geometry(11'h7FF, 11'h7FF, 0);
      for (int i = 0; i < 3; i++) send_item(KIND_PIXEL, 8'($urandom));
      set_geometry(1024, 1024, 4);
      for (int i = 0; i < 3; i++) send_item(KIND_PIXEL, 8'($urandom));
      // A single column at full height with radius 5 clamped to 4.
      set_geometry(1, 1024, 5);
      for (int i = 0; i < 6; i++) send_item(KIND_PIXEL, 8'($urandom));
   endtask

   // Random geometry and content. Every third setting runs without idling.
   task automatic test_random_frames(int item_target);
      int unsigned w;
      int unsigned h;
      while (item_count < item_target) begin
         w = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 16);
         h = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 8);
         set_geometry(w, h, $urandom_range(0, 4));
         no_idle = (setting_count % 3 == 0);
         send_frame();
         if ($urandom_range(0, 1)) send_frame();
         no_idle = 1'b0;
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps going,
   // so the block fills and stalls its input.
   task automatic test_result_stall();
      set_geometry(8, 6, 1);
      rsp_hold = 400;
      send_frame();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_geometry();
      test_small_frame();
      test_saturation();
      test_result_stall();
      test_random_frames(550);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_medians.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d transactions over %0d geometry settings.", item_count, setting_count);
      $display("Checked %0d medians across %0d complete frames.", median_count, frame_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- window_median_filter_core.f -----
hdl/wmf_pkg.sv
hdl/window_median_filter_core.sv
tb/window_median_filter_core_test.sv
